// ===== hdl/ags_pkg.sv =====
// ----------------------------------------------------------------------------
// ags_pkg: shared types and constants for the auto-ranging gain scanner
// Word formats, register indexes, gain codes and sizing constants.
// ----------------------------------------------------------------------------
package ags_pkg;

  // Scanner sizing
  localparam int CHANNELS      = 8;
  localparam int MAX_GAIN_CODE = 5;
  localparam int READING_BITS  = 16;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GAIN_W = 3;
  localparam int VOLT_W = 13;

  // Gain codes
  localparam logic [GAIN_W-1:0] GAIN_HALF  = 3'd0;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 3'd1;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(MAX_GAIN_CODE);

  localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 2'd2;

  localparam logic [11:0] VREF_RST     = 12'd2400;
  localparam logic [15:0] LOW_THR_RST  = 16'h7F00;
  localparam logic [15:0] HIGH_THR_RST = 16'hFF00;

  typedef struct packed {
    logic [15:0] reading;
    logic        auto_adjust;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        channel;
    logic [GAIN_W-1:0] gain_code;
    logic              remeasure;
    logic [VOLT_W-1:0] voltage_mv;
    logic [2:0]        next_channel;
    logic [GAIN_W-1:0] next_gain_code;
    logic              scan_complete;
  } out_word_t;

  // Operands handed to the ranging datapath
  typedef struct packed {
    logic [15:0]       reading;
    logic              auto_adjust;
    logic [GAIN_W-1:0] gain;
    logic [11:0]       vref_mv;
    logic [15:0]       low_thr;
    logic [15:0]       high_thr;
  } range_req_t;

  // Decision returned by the ranging datapath
  typedef struct packed {
    logic              redo;
    logic [GAIN_W-1:0] new_gain;
    logic [VOLT_W-1:0] voltage_mv;
  } range_dec_t;

endpackage

// ===== hdl/ags_ranger.sv =====
// ----------------------------------------------------------------------------
// ags_ranger: gain decision and voltage scaling
// Picks the new gain for one reading and scales the reading to millivolts.
// ----------------------------------------------------------------------------
module ags_ranger (
  input  ags_pkg::range_req_t req,
  output ags_pkg::range_dec_t dec
);

  localparam int PROD_W  = 16 + 12;
  localparam int SHAMT_W = 5;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    doubled;
  logic [SHAMT_W-1:0] shamt;
  logic [PROD_W:0]    scaled;
  logic               is_low;
  logic               is_high;

  assign is_low  = (req.reading <= req.low_thr);
  assign is_high = (req.reading >= req.high_thr);

  // voltage = (reading * 2 * vref) >> (READING_BITS + gain), saturated
  assign prod    = PROD_W'(req.reading) * PROD_W'(req.vref_mv);
  assign doubled = {prod, 1'b0};
  assign shamt   = SHAMT_W'(ags_pkg::READING_BITS) + SHAMT_W'(req.gain);
  assign scaled  = doubled >> shamt;

  always_comb begin
    dec.redo     = 1'b0;
    dec.new_gain = req.gain;
    if (req.auto_adjust) begin
      // low test wins when both thresholds are met
      if (is_low) begin
        if (req.gain < ags_pkg::GAIN_MAX) begin
          dec.new_gain = req.gain + 1'b1;
          dec.redo     = 1'b1;
        end
      end else if (is_high) begin
        if (req.gain != ags_pkg::GAIN_HALF) begin
          dec.new_gain = req.gain - 1'b1;
          dec.redo     = 1'b1;
        end
      end
    end else if (req.gain != ags_pkg::GAIN_UNITY) begin
      dec.new_gain = ags_pkg::GAIN_UNITY;
      dec.redo     = 1'b1;
    end

    if (dec.redo) begin
      dec.voltage_mv = '0;
    end else if (scaled > (PROD_W + 1)'(ags_pkg::VOLT_MAX)) begin
      dec.voltage_mv = ags_pkg::VOLT_MAX;
    end else begin
      dec.voltage_mv = scaled[ags_pkg::VOLT_W-1:0];
    end
  end

endmodule

// ===== hdl/autorange_gain_scanner_top.sv =====
// ----------------------------------------------------------------------------
// autorange_gain_scanner_top: ADC channel scanner with per-channel PGA gain
// Ring scan of ADC channels, auto-ranging gain per channel, mV scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per ADC reading of the channel currently selected.
//           Accepted when in_valid is high and in_stall is low.
//   out_* : one word per reading: channel, gain used, re-read flag, voltage,
//           and the mux channel and gain code to program for the next sample.
//   cfg_* : write-only registers (0 vref_mv, 1 low_threshold,
//           2 high_threshold), written when cfg_we is high. Write only idle.
// Pipeline: a word passes the input register, then the result register;
//   out_valid rises as the word moves into the result register. Throughput:
//   one word per cycle while out_stall is low; the gain table and channel
//   pointer update in the same cycle a word moves into the result
//   register, so the next word sees them at once.
// Stall: out_stall holds the result register; a word waiting in the input
//   register raises in_stall only when the result register cannot drain.
// Reset (rst_n low, synchronous): all gains x1, channel 0, registers to
//   vref 2400 mV, thresholds 0x7F00 / 0xFF00, both stages empty.
// ----------------------------------------------------------------------------
module autorange_gain_scanner_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ags_pkg::in_word_t                    in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ags_pkg::out_word_t                   out_data,
  // configuration
  input  logic                                 cfg_we,
  input  logic [ags_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ags_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam logic [ags_pkg::CH_W-1:0] CH_LAST = ags_pkg::CH_W'(ags_pkg::CHANNELS - 1);

  // config registers
  logic [11:0] vref_r;
  logic [15:0] low_thr_r;
  logic [15:0] high_thr_r;

  // input stage
  logic               s1_valid_r, s1_valid_nxt;
  ags_pkg::in_word_t  s1_word_r;

  // result stage
  logic               out_valid_r, out_valid_nxt;
  ags_pkg::out_word_t out_word_r, out_word_nxt;

  // scan state
  logic [ags_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [ags_pkg::GAIN_W-1:0] cur_gain_r, cur_gain_nxt;
  logic [ags_pkg::GAIN_W-1:0] gain_tbl_r [ags_pkg::CHANNELS];

  logic                     s1_adv;
  logic                     in_accept;
  logic                     wrap;
  logic [ags_pkg::CH_W-1:0] ch_inc;
  ags_pkg::range_req_t      req;
  ags_pkg::range_dec_t      dec;

  // handshake: input stage drains when the result register is free
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r     <= ags_pkg::VREF_RST;
      low_thr_r  <= ags_pkg::LOW_THR_RST;
      high_thr_r <= ags_pkg::HIGH_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ags_pkg::CFG_VREF_MV:  vref_r     <= cfg_wdata[11:0];
        ags_pkg::CFG_LOW_THR:  low_thr_r  <= cfg_wdata[15:0];
        ags_pkg::CFG_HIGH_THR: high_thr_r <= cfg_wdata[15:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ranging datapath for the word in the input stage
  assign req.reading     = s1_word_r.reading;
  assign req.auto_adjust = s1_word_r.auto_adjust;
  assign req.gain        = cur_gain_r;
  assign req.vref_mv     = vref_r;
  assign req.low_thr     = low_thr_r;
  assign req.high_thr    = high_thr_r;

  ags_ranger u_ranger (
    .req (req),
    .dec (dec)
  );

  // next channel: stay on a re-read, else step around the ring
  assign wrap   = !dec.redo && (ch_r == CH_LAST);
  assign ch_inc = (ch_r == CH_LAST) ? '0 : ch_r + 1'b1;

  always_comb begin
    ch_nxt       = ch_r;
    cur_gain_nxt = dec.new_gain;
    if (!dec.redo) begin
      ch_nxt = ch_inc;
      // single-channel ring reads back the entry just written
      if (ch_inc != ch_r) begin
        cur_gain_nxt = gain_tbl_r[ch_inc];
      end
    end
  end

  always_comb begin
    out_word_nxt.channel        = 3'(ch_r);
    out_word_nxt.gain_code      = cur_gain_r;
    out_word_nxt.remeasure      = dec.redo;
    out_word_nxt.voltage_mv     = dec.voltage_mv;
    out_word_nxt.next_channel   = 3'(ch_nxt);
    out_word_nxt.next_gain_code = cur_gain_nxt;
    out_word_nxt.scan_complete  = wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      cur_gain_r  <= ags_pkg::GAIN_UNITY;
      for (int i = 0; i < ags_pkg::CHANNELS; i++) begin
        gain_tbl_r[i] <= ags_pkg::GAIN_UNITY;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        ch_r             <= ch_nxt;
        cur_gain_r       <= cur_gain_nxt;
        gain_tbl_r[ch_r] <= dec.new_gain;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_data;
    end
    if (s1_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

`ifndef SYNTHESIS
  // a word in the input stage is held, not dropped, while the result stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("input stage word lost under stall");

  // re-read keeps the channel, reports no voltage and no wrap
  a_redo_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.remeasure |->
      out_word_r.next_channel == out_word_r.channel &&
      out_word_r.voltage_mv == '0 && !out_word_r.scan_complete)
    else $error("re-read word inconsistent");

  // cached gain never leaves the legal range
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_gain_r <= ags_pkg::GAIN_MAX)
    else $error("gain code out of range");

  // channel pointer stays inside the ring
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= CH_LAST)
    else $error("channel pointer out of range");

  // cached gain matches the table entry of the current channel
  a_gain_cache: assert property (@(posedge clk) disable iff (!rst_n)
    cur_gain_r == gain_tbl_r[ch_r])
    else $error("gain cache out of step with table");
`endif

endmodule
